### src/ctc_pkg.sv
// Shared types, codes and the thermistor table of the chiller thermostat controller.
package ctc_pkg;

   localparam int NTC_ENTRIES = 51;
   localparam logic [9:0] NTC_TBL [NTC_ENTRIES] = '{
      10'd860, 10'd851, 10'd842, 10'd833, 10'd823, 10'd814, 10'd804, 10'd793, 10'd783,
      10'd772, 10'd761, 10'd750, 10'd738, 10'd727, 10'd715, 10'd703, 10'd691, 10'd679,
      10'd666, 10'd654, 10'd641, 10'd628, 10'd616, 10'd603, 10'd590, 10'd577, 10'd564,
      10'd552, 10'd539, 10'd526, 10'd514, 10'd501, 10'd489, 10'd476, 10'd464, 10'd452,
      10'd440, 10'd428, 10'd417, 10'd406, 10'd394, 10'd383, 10'd373, 10'd362, 10'd352,
      10'd341, 10'd331, 10'd322, 10'd312, 10'd303, 10'd294
   };

   localparam logic [2:0] MODE_OFF  = 3'd0;
   localparam logic [2:0] MODE_ON   = 3'd1;
   localparam logic [2:0] MODE_FAN  = 3'd2;
   localparam logic [2:0] MODE_COMP = 3'd3;
   localparam logic [2:0] MODE_WARM = 3'd4;

   localparam logic [2:0] CSR_CIRC_TARGET  = 3'd0;
   localparam logic [2:0] CSR_STORE_MAX    = 3'd1;
   localparam logic [2:0] CSR_STORE_MIN    = 3'd2;
   localparam logic [2:0] CSR_FAN_POST_RUN = 3'd3;
   localparam logic [2:0] CSR_LOOP_GAIN    = 3'd4;

   localparam logic [9:0] SLOW_DUTY_LEVEL = 10'd512;
   localparam logic signed [10:0] WARMUP_SECONDS = 11'sd4;
   localparam logic signed [9:0] TEMP_LOW  = -10'sd200;
   localparam logic signed [9:0] TEMP_HIGH = 10'sd300;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE,
      ST_SMOOTH,
      ST_MULT,
      ST_FINISH
   } ctc_state_type;

   typedef struct packed {
      logic       load;
      logic       search;
      logic       divide;
      logic       smooth;
      logic       mult;
      logic       commit;
      logic       sel;
      logic [2:0] step;
   } ctc_cmd_type;

   function automatic logic [9:0] ctc_ntc(input logic [5:0] idx);
      logic [9:0] val;
      val = '0;
      if (idx < 6'(NTC_ENTRIES)) begin
         val = NTC_TBL[idx];
      end
      return val;
   endfunction

endpackage

### src/chiller_thermostat_controller.sv
// Top level of the chiller thermostat controller: sequencer plus datapath.
//
// One input word is one control tick: two raw thermistor samples and a power
// request. Each sample is located in the 51-entry thermistor table by a
// six-step binary search, interpolated by a four-step divider, and smoothed
// by a tenth of the error; then the integral loop product is registered and
// the loop, slow duty and mode machine commit together. The two samples take
// serial search-and-divide passes, one after the other; the next word is
// taken in the cycle after the result is loaded, even if that result is
// still held by rsp_stall. The user must write config registers through
// csr_write/csr_index/csr_wdata only while idle; the block does not enforce it.
module chiller_thermostat_controller import ctc_pkg::*; #(
   parameter int INTEGRATOR_FRACTION = 16,
   parameter int TICKS_PER_SEC       = 59
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [9:0]        req_store_adc,
   input  logic [9:0]        req_circ_adc,
   input  logic              req_power_request,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_mode,
   output logic              rsp_compressor_relay,
   output logic              rsp_fan_relay,
   output logic              rsp_pump_on,
   output logic [9:0]        rsp_cooling_speed,
   output logic signed [9:0] rsp_store_temp,
   output logic signed [9:0] rsp_circ_temp
);

   ctc_cmd_type cmd;

   // sequencing of one tick
   ctc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // conversion, loop and mode state
   ctc_dp #(
      .INTEGRATOR_FRACTION (INTEGRATOR_FRACTION),
      .TICKS_PER_SEC       (TICKS_PER_SEC)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_store_adc        (req_store_adc),
      .req_circ_adc         (req_circ_adc),
      .req_power_request    (req_power_request),
      .rsp_mode             (rsp_mode),
      .rsp_compressor_relay (rsp_compressor_relay),
      .rsp_fan_relay        (rsp_fan_relay),
      .rsp_pump_on          (rsp_pump_on),
      .rsp_cooling_speed    (rsp_cooling_speed),
      .rsp_store_temp       (rsp_store_temp),
      .rsp_circ_temp        (rsp_circ_temp)
   );

endmodule

### src/ctc_ctrl.sv
// Tick sequencer: steps the datapath through search, divide, smooth, loop and commit.
module ctc_ctrl import ctc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ctc_cmd_type cmd
);

   ctc_state_type state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic          sel_ff, sel_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEARCH;
               step_in  = 3'd5;
               sel_in   = 1'b0;
            end
         end
         ST_SEARCH: begin
            if (step_ff == 3'd0) begin
               state_in = ST_DIVIDE;
               step_in  = 3'd3;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ST_DIVIDE: begin
            if (step_ff == 3'd0) begin
               state_in = ST_SMOOTH;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         ST_SMOOTH: begin
            if (!sel_ff) begin
               state_in = ST_SEARCH;
               step_in  = 3'd5;
               sel_in   = 1'b1;
            end else begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.sel    = sel_ff;
      cmd.step   = step_ff;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SEARCH: cmd.search = 1'b1;
         ST_DIVIDE: cmd.divide = 1'b1;
         ST_SMOOTH: cmd.smooth = 1'b1;
         ST_MULT:   cmd.mult   = 1'b1;
         ST_FINISH: cmd.commit = out_free;
         default:   req_stall  = 1'b1;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_SEARCH && step_ff == 3'd5 && !sel_ff)
      else $error("accepted word did not start a search");
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("commit did not present a result");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit over a held result");
`endif

endmodule

### src/ctc_dp.sv
// Datapath: table search, interpolation divide, smoothing, integral loop and mode logic.
module ctc_dp import ctc_pkg::*; #(
   parameter int INTEGRATOR_FRACTION = 16,
   parameter int TICKS_PER_SEC       = 59
) (
   input  logic              clock,
   input  logic              reset,
   input  ctc_cmd_type       cmd,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic [9:0]        req_store_adc,
   input  logic [9:0]        req_circ_adc,
   input  logic              req_power_request,
   output logic [2:0]        rsp_mode,
   output logic              rsp_compressor_relay,
   output logic              rsp_fan_relay,
   output logic              rsp_pump_on,
   output logic [9:0]        rsp_cooling_speed,
   output logic signed [9:0] rsp_store_temp,
   output logic signed [9:0] rsp_circ_temp
);

   localparam int IW   = 10 + INTEGRATOR_FRACTION;
   localparam int SW   = ((IW > 29) ? IW : 29) + 2;
   localparam logic [IW-1:0] INTEG_TOP = {10'd1023, {INTEGRATOR_FRACTION{1'b0}}};
   localparam logic [8:0]  SLOW_PERIOD = 9'(5 * TICKS_PER_SEC);
   localparam logic [5:0]  TPS = 6'(TICKS_PER_SEC);

   // configuration
   logic signed [9:0] circ_target_ff, store_max_ff, store_min_ff;
   logic [9:0]        fan_post_run_ff;
   logic [15:0]       loop_gain_ff;

   // captured word
   logic [9:0] store_raw_ff, circ_raw_ff;
   logic       power_ff;

   // working registers
   logic [5:0] idx_ff, idx_in;
   logic [7:0] rem_ff, rem_in;
   logic [3:0] quo_ff, quo_in;
   logic signed [28:0] prod_ff;

   // control state
   logic signed [9:0]  store_sm_ff, circ_sm_ff, sm_new;
   logic [IW-1:0]      integ_ff, integ_in;
   logic [8:0]         duty_ff, duty_in;
   logic [5:0]         tick_ff, tick_in;
   logic signed [10:0] secs_ff, secs_in;
   logic [2:0]         mode_ff, mode_in;
   logic [9:0]         speed_in;

   // table search, one bit of the index per step
   logic [9:0] raw_cur;
   logic [5:0] idx_base, cand;
   assign raw_cur  = cmd.sel ? circ_raw_ff : store_raw_ff;
   assign idx_base = (cmd.step == 3'd5) ? 6'd0 : idx_ff;
   assign cand     = idx_base | (6'd1 << cmd.step);

   always_comb begin
      idx_in = idx_base;
      if (cand <= 6'(NTC_ENTRIES) && ctc_ntc(cand - 6'd1) > raw_cur) begin
         idx_in = cand;
      end
   end

   // interpolation divide, quotient below ten so four steps
   logic [9:0] lower, upper;
   logic [3:0] den, off4;
   logic [7:0] num, rem_base, den_sh;
   logic [3:0] quo_base;
   assign lower    = ctc_ntc(idx_ff);
   assign upper    = ctc_ntc(idx_ff - 6'd1);
   assign den      = 4'(upper - lower);
   assign off4     = 4'(raw_cur - lower);
   assign num      = 8'({4'b0, off4} * 8'd10);
   assign rem_base = (cmd.step == 3'd3) ? num : rem_ff;
   assign quo_base = (cmd.step == 3'd3) ? 4'd0 : quo_ff;
   assign den_sh   = 8'({4'b0, den} << cmd.step[1:0]);

   always_comb begin
      rem_in = rem_base;
      quo_in = quo_base;
      if (rem_base >= den_sh) begin
         rem_in = rem_base - den_sh;
         quo_in = quo_base | (4'd1 << cmd.step[1:0]);
      end
   end

   // tenths and smoothing; divide by ten as multiply by 205 and shift by 11
   logic signed [10:0] t_base, t_lin, d;
   logic signed [9:0]  t10, x;
   logic [8:0]         mag;
   logic [5:0]         q10;
   logic [17:0]        mul205;
   assign t_base = $signed({5'b0, idx_ff}) - 11'sd20;
   assign t_lin  = 11'(t_base * 11'sd10) - $signed({7'b0, quo_ff});

   always_comb begin
      if (idx_ff == 6'd0) begin
         t10 = TEMP_LOW;
      end else if (idx_ff == 6'(NTC_ENTRIES)) begin
         t10 = TEMP_HIGH;
      end else begin
         t10 = 10'(t_lin);
      end
   end

   assign x      = cmd.sel ? circ_sm_ff : store_sm_ff;
   assign d      = {t10[9], t10} - {x[9], x};
   assign mag    = d[10] ? 9'(-d) : 9'(d);
   assign mul205 = {9'b0, mag} * 18'd205;
   assign q10    = 6'(mul205 >> 11);
   assign sm_new = d[10] ? x - $signed({4'b0, q10}) : x + $signed({4'b0, q10});

   // integral loop and mode update, applied on commit
   logic signed [11:0] err;
   logic signed [SW-1:0] sum;
   logic [9:0] co;
   logic [17:0] duty_prod;
   logic [8:0]  duty_lim;
   logic [5:0]  tick_inc;
   assign err = {{2{circ_target_ff[9]}}, circ_target_ff} - {{2{circ_sm_ff[9]}}, circ_sm_ff};
   assign sum = $signed({{(SW-IW){1'b0}}, integ_ff}) - SW'(prod_ff);
   assign tick_inc = tick_ff + 6'd1;

   always_comb begin
      integ_in = integ_ff;
      duty_in  = duty_ff;
      tick_in  = tick_ff;
      secs_in  = secs_ff;
      mode_in  = mode_ff;
      speed_in = '0;
      co       = '0;
      duty_prod = '0;
      duty_lim  = '0;
      if (mode_ff == MODE_OFF) begin
         if (power_ff) begin
            mode_in = MODE_ON;
         end
      end else begin
         if (sum < 0) begin
            integ_in = '0;
         end else if (sum > $signed({{(SW-IW){1'b0}}, INTEG_TOP})) begin
            integ_in = INTEG_TOP;
         end else begin
            integ_in = IW'(sum);
         end
         co = integ_in[IW-1 -: 10];
         if (co < SLOW_DUTY_LEVEL) begin
            duty_in   = (duty_ff > SLOW_PERIOD) ? 9'd0 : duty_ff + 9'd1;
            duty_prod = {9'b0, co[8:0]} * {9'b0, SLOW_PERIOD};
            duty_lim  = duty_prod[17:9];
            speed_in  = (duty_in < duty_lim) ? SLOW_DUTY_LEVEL : 10'd0;
         end else begin
            speed_in = co;
         end
         case (mode_ff)
            MODE_ON: begin
               if (power_ff) begin
                  if (store_sm_ff > store_max_ff) begin
                     mode_in = MODE_WARM;
                     secs_in = WARMUP_SECONDS;
                     tick_in = '0;
                  end
               end else begin
                  mode_in  = MODE_OFF;
                  speed_in = '0;
               end
            end
            MODE_WARM: begin
               tick_in = tick_inc;
               if (tick_inc >= TPS) begin
                  tick_in = '0;
                  secs_in = secs_ff - 11'sd1;
                  if (secs_in <= 0) begin
                     mode_in = MODE_COMP;
                  end
               end
            end
            MODE_COMP: begin
               if (store_sm_ff < store_min_ff || !power_ff) begin
                  mode_in = MODE_FAN;
                  secs_in = $signed({1'b0, fan_post_run_ff});
                  tick_in = '0;
               end
            end
            MODE_FAN: begin
               tick_in = tick_inc;
               if (tick_inc >= TPS) begin
                  tick_in = '0;
                  secs_in = secs_ff - 11'sd1;
                  if (store_sm_ff > store_max_ff) begin
                     mode_in = MODE_COMP;
                  end else if (secs_in <= 0) begin
                     mode_in = MODE_ON;
                  end
               end
            end
            default: mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_target_ff  <= 10'sd200;
         store_max_ff    <= 10'sd50;
         store_min_ff    <= 10'sd0;
         fan_post_run_ff <= 10'd30;
         loop_gain_ff    <= 16'd10000;
         store_sm_ff     <= '0;
         circ_sm_ff      <= '0;
         integ_ff        <= '0;
         duty_ff         <= '0;
         tick_ff         <= '0;
         secs_ff         <= '0;
         mode_ff         <= MODE_OFF;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CIRC_TARGET:  circ_target_ff  <= csr_wdata[9:0];
               CSR_STORE_MAX:    store_max_ff    <= csr_wdata[9:0];
               CSR_STORE_MIN:    store_min_ff    <= csr_wdata[9:0];
               CSR_FAN_POST_RUN: fan_post_run_ff <= csr_wdata[9:0];
               CSR_LOOP_GAIN:    loop_gain_ff    <= csr_wdata;
               default:          loop_gain_ff    <= loop_gain_ff;
            endcase
         end
         if (cmd.smooth) begin
            if (cmd.sel) begin
               circ_sm_ff <= sm_new;
            end else begin
               store_sm_ff <= sm_new;
            end
         end
         if (cmd.commit) begin
            integ_ff <= integ_in;
            duty_ff  <= duty_in;
            tick_ff  <= tick_in;
            secs_ff  <= secs_in;
            mode_ff  <= mode_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         store_raw_ff <= req_store_adc;
         circ_raw_ff  <= req_circ_adc;
         power_ff     <= req_power_request;
      end
      if (cmd.search) begin
         idx_ff <= idx_in;
      end
      if (cmd.divide) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.mult) begin
         prod_ff <= 29'(err) * $signed({13'b0, loop_gain_ff});
      end
      if (cmd.commit) begin
         rsp_mode             <= mode_in;
         rsp_compressor_relay <= (mode_in == MODE_COMP);
         rsp_fan_relay        <= (mode_in == MODE_COMP) || (mode_in == MODE_FAN)
                                 || (mode_in == MODE_WARM);
         rsp_pump_on          <= (mode_in != MODE_OFF);
         rsp_cooling_speed    <= speed_in;
         rsp_store_temp       <= store_sm_ff;
         rsp_circ_temp        <= circ_sm_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      integ_ff <= INTEG_TOP)
      else $error("integrator above its ceiling");
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= SLOW_PERIOD + 9'd1)
      else $error("slow duty counter past its period");
   a_tick_range: assert property (@(posedge clock) disable iff (reset)
      tick_ff < TPS)
      else $error("tick counter past one second");
`endif

endmodule

### tb/chiller_thermostat_controller_tb.sv
// Self-checking testbench for the chiller thermostat controller.
`timescale 1ns / 100ps

module chiller_thermostat_controller_tb import ctc_pkg::*; ();

   localparam int FRAC      = 16;
   localparam int TPS       = 59;
   localparam int SLOW_TOP  = 5 * TPS;
   localparam int LATENCY   = 24;
   localparam int CYCLE_CAP = 1000000;

   // Expected result word.
   typedef struct packed {
      logic [2:0]        mode;
      logic              comp;
      logic              fan;
      logic              pump;
      logic [9:0]        speed;
      logic signed [9:0] store_t;
      logic signed [9:0] circ_t;
   } tick_out_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [15:0]       csr_wdata = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [9:0]        req_store_adc = '0;
   logic [9:0]        req_circ_adc = '0;
   logic              req_power_request = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [2:0]        rsp_mode;
   logic              rsp_compressor_relay;
   logic              rsp_fan_relay;
   logic              rsp_pump_on;
   logic [9:0]        rsp_cooling_speed;
   logic signed [9:0] rsp_store_temp;
   logic signed [9:0] rsp_circ_temp;

   chiller_thermostat_controller DUT (.*);

   always #1 clock = ~clock;

   // Predictor state: configuration and controller state.
   int        circ_target, store_max, store_min, fan_post_run, loop_gain;
   logic [2:0] mode_q;
   int        store_avg, circ_avg;
   longint    integ;
   int        duty_cnt, tick_cnt, secs_left;

   tick_out_type expected_ticks[$];
   int        errors = 0;
   longint    cycles = 0;

   function automatic int sx10(int v);
      v = v & 10'h3ff;
      return (v >= 512) ? v - 1024 : v;
   endfunction

   // Raw sample to tenths of a degree by table search with interpolation.
   function automatic int adc_to_tenths(int raw);
      int hi;
      int lo;
      hi = 1024;
      if (raw >= int'(NTC_TBL[0])) return -200;
      for (int i = 0; i < NTC_ENTRIES; i++) begin
         lo = int'(NTC_TBL[i]);
         if (lo <= raw) return (i - 20) * 10 - ((raw - lo) * 10) / (hi - lo);
         hi = lo;
      end
      return 300;
   endfunction

   task automatic predict_reset();
      circ_target = 200; store_max = 50; store_min = 0;
      fan_post_run = 30; loop_gain = 10000;
      mode_q = MODE_OFF; store_avg = 0; circ_avg = 0; integ = 0;
      duty_cnt = 0; tick_cnt = 0; secs_left = 0;
   endtask

   // One control tick of the controller.
   function automatic tick_out_type predict_tick(int s_adc, int c_adc, bit pwr);
      tick_out_type r;
      int        speed;
      int        co;
      longint    err;
      longint    top;
      speed = 0;
      top = longint'(1023) << FRAC;
      store_avg = store_avg + (adc_to_tenths(s_adc) - store_avg) / 10;
      circ_avg = circ_avg + (adc_to_tenths(c_adc) - circ_avg) / 10;
      if (mode_q == MODE_OFF) begin
         if (pwr) mode_q = MODE_ON;
      end else begin
         err = longint'(sx10(circ_target)) - longint'(circ_avg);
         integ = integ - err * longint'(loop_gain);
         if (integ > top) integ = top;
         else if (integ < 0) integ = 0;
         co = int'(integ >>> FRAC);
         if (co < 512) begin
            duty_cnt = (duty_cnt > SLOW_TOP) ? 0 : duty_cnt + 1;
            speed = (duty_cnt < (SLOW_TOP * co) / 512) ? 512 : 0;
         end else begin
            speed = co;
         end
         case (mode_q)
            MODE_ON: begin
               if (pwr) begin
                  if (store_avg > sx10(store_max)) begin
                     mode_q = MODE_WARM; secs_left = 4; tick_cnt = 0;
                  end
               end else begin
                  mode_q = MODE_OFF; speed = 0;
               end
            end
            MODE_WARM: begin
               tick_cnt++;
               if (tick_cnt >= TPS) begin
                  tick_cnt = 0; secs_left--;
                  if (secs_left <= 0) mode_q = MODE_COMP;
               end
            end
            MODE_COMP: begin
               if (store_avg < sx10(store_min) || !pwr) begin
                  mode_q = MODE_FAN; secs_left = fan_post_run; tick_cnt = 0;
               end
            end
            MODE_FAN: begin
               tick_cnt++;
               if (tick_cnt >= TPS) begin
                  tick_cnt = 0; secs_left--;
                  if (store_avg > sx10(store_max)) mode_q = MODE_COMP;
                  else if (secs_left <= 0) mode_q = MODE_ON;
               end
            end
            default: ;
         endcase
      end
      r.mode    = mode_q;
      r.comp    = (mode_q == MODE_COMP);
      r.fan     = (mode_q == MODE_COMP || mode_q == MODE_FAN || mode_q == MODE_WARM);
      r.pump    = (mode_q != MODE_OFF);
      r.speed   = speed[9:0];
      r.store_t = store_avg[9:0];
      r.circ_t  = circ_avg[9:0];
      return r;
   endfunction

   // Send one tick word; prediction is made when it is accepted.
   // Valid stays up into a back-to-back word, drops only for an idle gap.
   task automatic send_tick(int s_adc, int c_adc, bit pwr);
      int idle;
      idle = $urandom_range(0, 4);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_store_adc <= s_adc[9:0];
      req_circ_adc <= c_adc[9:0];
      req_power_request <= pwr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_ticks.push_back(predict_tick(s_adc, c_adc, pwr));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Register write; only used with nothing in flight.
   task automatic write_csr(logic [2:0] idx, int val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_CIRC_TARGET:  circ_target = val & 10'h3ff;
         CSR_STORE_MAX:    store_max = val & 10'h3ff;
         CSR_STORE_MIN:    store_min = val & 10'h3ff;
         CSR_FAN_POST_RUN: fan_post_run = val & 10'h3ff;
         CSR_LOOP_GAIN:    loop_gain = val & 16'hffff;
         default: ;
      endcase
   endtask

   // Random stall on the result side, drawn per word, with calm stretches.
   int stall_left = 0;
   bit calm = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (($urandom_range(0, 99)) < 3) calm <= ~calm;
            stall_left <= calm ? 0 : $urandom_range(0, 4);
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end
         rsp_stall <= (stall_left > 1) || (rsp_valid && !rsp_stall && !calm
                      && ($urandom_range(0, 1) == 1));
      end
   end

   // Result checker.
   always @(posedge clock) begin
      tick_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ticks.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_ticks.pop_front();
            if (rsp_mode !== e.mode) begin
               $error("mode exp %0d got %0d", e.mode, rsp_mode); errors++;
            end
            if (rsp_compressor_relay !== e.comp) begin
               $error("compressor_relay exp %0d got %0d", e.comp, rsp_compressor_relay);
               errors++;
            end
            if (rsp_fan_relay !== e.fan) begin
               $error("fan_relay exp %0d got %0d", e.fan, rsp_fan_relay); errors++;
            end
            if (rsp_pump_on !== e.pump) begin
               $error("pump_on exp %0d got %0d", e.pump, rsp_pump_on); errors++;
            end
            if (rsp_cooling_speed !== e.speed) begin
               $error("cooling_speed exp %0d got %0d", e.speed, rsp_cooling_speed);
               errors++;
            end
            if (rsp_store_temp !== e.store_t) begin
               $error("store_temp exp %0d got %0d", e.store_t, rsp_store_temp); errors++;
            end
            if (rsp_circ_temp !== e.circ_t) begin
               $error("circ_temp exp %0d got %0d", e.circ_t, rsp_circ_temp); errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Table edges, both field extremes, and power toggling through off.
   task automatic test_directed();
      int pts[10] = '{0, 293, 294, 295, 514, 859, 860, 861, 1022, 1023};
      for (int i = 0; i < 10; i++) send_tick(pts[i], pts[9 - i], i[0]);
      send_tick(1023, 0, 1'b1);
      send_tick(0, 1023, 1'b0);
      send_tick(10'h155, 10'h2aa, 1'b1);
      send_tick(10'h2aa, 10'h155, 1'b1);
      send_tick(500, 500, 1'b0);
   endtask

   // Full cycle: on, warmup, compressor, fan run-out, back to on.
   task automatic test_mode_cycle(int n, int hot, bit pwr_drop);
      for (int i = 0; i < n; i++) begin
         bit pwr;
         int s;
         pwr = !(pwr_drop && i > n / 2 && i < n / 2 + 5) || ($urandom_range(0, 15) == 0);
         s = (i < n / 3) ? hot + $urandom_range(0, 20) : $urandom_range(294, 1023);
         send_tick(s, $urandom_range(0, 1023), pwr);
      end
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++)
         send_tick($urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 7) != 0);
   endtask

   initial begin
      predict_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      drain();

      // Warm store, short fan run-out; loop at full gain.
      write_csr(CSR_STORE_MAX, -200);
      write_csr(CSR_STORE_MIN, -150);
      write_csr(CSR_FAN_POST_RUN, 0);
      write_csr(CSR_LOOP_GAIN, 16'hffff);
      write_csr(CSR_CIRC_TARGET, 300);
      write_csr(3'd7, 16'h1234);
      test_mode_cycle(400, 294, 1'b1);
      drain();

      // Cold extremes and zero gain; low target keeps the loop near zero.
      write_csr(CSR_CIRC_TARGET, -200);
      write_csr(CSR_STORE_MAX, 300);
      write_csr(CSR_STORE_MIN, 300);
      write_csr(CSR_FAN_POST_RUN, 1023);
      write_csr(CSR_LOOP_GAIN, 0);
      test_random(150);
      drain();

      // Moderate settings, slow duty region with small gain.
      write_csr(CSR_CIRC_TARGET, 100);
      write_csr(CSR_STORE_MAX, 0);
      write_csr(CSR_STORE_MIN, -100);
      write_csr(CSR_FAN_POST_RUN, 2);
      write_csr(CSR_LOOP_GAIN, 300);
      test_mode_cycle(450, 500, 1'b1);
      drain();

      write_csr(CSR_LOOP_GAIN, $urandom_range(1000, 40000));
      write_csr(CSR_CIRC_TARGET, $urandom_range(0, 300));
      test_random(400);
      drain();

      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
